// File: rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the great-circle distance unit.
// No dependencies; every other file imports this package.
package gcd_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STEPS    = 31;
    localparam int CW            = 34;
    localparam int SW            = 62;
    localparam int SQ_IN_W       = 61;
    localparam int SQ_OUT_W      = 31;

    typedef logic signed [CW-1:0] t_cw;

    typedef struct packed {
        t_cw x;
        t_cw y;
        t_cw z;
    } t_cordic_vec;

    typedef struct packed {
        logic [SW-1:0] rem;
        logic [SW-1:0] root;
    } t_sqrt_vec;

    localparam t_cw               INV_GAIN     = 34'sd652032874;
    localparam logic [31:0]       RAD_K        = 32'd4024455254;
    localparam logic signed [33:0] FULL_TURN   = 34'sd3600000000;
    localparam logic signed [33:0] TWO_TURNS   = 34'sd7200000000;
    localparam logic signed [33:0] HALF_TURN   = 34'sd1800000000;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;
    localparam logic [30:0]       Q30_ONE      = 31'h4000_0000;

    // atan(2^-i) in Q4.30
    function automatic t_cw atan_q30(input logic [5:0] i);
        t_cw res;
        case (i)
            6'd0:    res = 34'sd843314857;
            6'd1:    res = 34'sd497837829;
            6'd2:    res = 34'sd263043837;
            6'd3:    res = 34'sd133525159;
            6'd4:    res = 34'sd67021687;
            6'd5:    res = 34'sd33543516;
            6'd6:    res = 34'sd16775851;
            6'd7:    res = 34'sd8388437;
            6'd8:    res = 34'sd4194283;
            6'd9:    res = 34'sd2097149;
            default: begin
                if (i inside {[6'd10:6'd30]}) res = t_cw'(1) <<< (6'd30 - i);
                else                          res = '0;
            end
        endcase
        return res;
    endfunction

endpackage

// File: rtl/gcd_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC micro-rotation with its output register, rotation or vectoring mode.
// Depends on gcd_pkg.
module gcd_cordic_cell (
    input  logic                 i_clk,
    input  logic [5:0]           i_step,
    input  logic                 i_vectoring,
    input  gcd_pkg::t_cordic_vec i_vec,
    output gcd_pkg::t_cordic_vec o_vec
);
    import gcd_pkg::*;

    t_cw         dx;
    t_cw         dy;
    t_cw         ang;
    logic        rot_pos;
    t_cordic_vec n_vec;
    t_cordic_vec r_vec;

    always_comb begin
        dx  = i_vec.y >>> i_step;
        dy  = i_vec.x >>> i_step;
        ang = atan_q30(i_step);
        // vectoring drives y towards zero, rotation drives z towards zero
        rot_pos = i_vectoring ? i_vec.y[CW-1] : !i_vec.z[CW-1];
        if (rot_pos) begin
            n_vec.x = i_vec.x - dx;
            n_vec.y = i_vec.y + dy;
            n_vec.z = i_vec.z - ang;
        end else begin
            n_vec.x = i_vec.x + dx;
            n_vec.y = i_vec.y - dy;
            n_vec.z = i_vec.z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;

endmodule

// File: rtl/gcd_cordic_chain.sv
`timescale 1ns / 1ps
// Row of CORDIC_STAGES CORDIC cells, one micro-rotation per cell and cycle.
// Depends on gcd_pkg and gcd_cordic_cell.
module gcd_cordic_chain (
    input  logic                 i_clk,
    input  logic                 i_vectoring,
    input  gcd_pkg::t_cordic_vec i_vec,
    output gcd_pkg::t_cordic_vec o_vec
);
    import gcd_pkg::*;

    t_cordic_vec w_vec [CORDIC_STAGES+1];

    assign w_vec[0] = i_vec;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        gcd_cordic_cell u_cell (
            .i_clk       (i_clk),
            .i_step      (6'(g)),
            .i_vectoring (i_vectoring),
            .i_vec       (w_vec[g]),
            .o_vec       (w_vec[g+1])
        );
    end

    assign o_vec = w_vec[CORDIC_STAGES];

endmodule

// File: rtl/gcd_sqrt_cell.sv
`timescale 1ns / 1ps
// One digit step of a restoring integer square root, registered.
// Depends on gcd_pkg.
module gcd_sqrt_cell (
    input  logic               i_clk,
    input  logic [4:0]         i_step,
    input  gcd_pkg::t_sqrt_vec i_vec,
    output gcd_pkg::t_sqrt_vec o_vec
);
    import gcd_pkg::*;

    logic [SW-1:0] place;
    logic [SW-1:0] trial;
    t_sqrt_vec     n_vec;
    t_sqrt_vec     r_vec;

    always_comb begin
        place = SW'(1) << {(5'(SQRT_STEPS - 1) - i_step), 1'b0};
        trial = i_vec.root + place;
        if (i_vec.rem >= trial) begin
            n_vec.rem  = i_vec.rem - trial;
            n_vec.root = (i_vec.root >> 1) + place;
        end else begin
            n_vec.rem  = i_vec.rem;
            n_vec.root = i_vec.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;

endmodule

// File: rtl/gcd_sqrt_chain.sv
`timescale 1ns / 1ps
// Row of SQRT_STEPS root cells giving the floor square root of a 61-bit value.
// Depends on gcd_pkg and gcd_sqrt_cell.
module gcd_sqrt_chain (
    input  logic                         i_clk,
    input  logic [gcd_pkg::SQ_IN_W-1:0]  i_n,
    output logic [gcd_pkg::SQ_OUT_W-1:0] o_root
);
    import gcd_pkg::*;

    t_sqrt_vec w_vec [SQRT_STEPS+1];

    assign w_vec[0].rem  = SW'(i_n);
    assign w_vec[0].root = '0;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_cell
        gcd_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_step (5'(g)),
            .i_vec  (w_vec[g]),
            .o_vec  (w_vec[g+1])
        );
    end

    assign o_root = w_vec[SQRT_STEPS].root[SQ_OUT_W-1:0];

endmodule

// File: rtl/great_circle_distance_unit.sv
`timescale 1ns / 1ps
// Haversine great-circle distance: two positions in 1e-7 degree in, centimetres out.
// One item per cycle through the rotation CORDIC rows, the 31-cell square-root rows and
// the vectoring CORDIC row.
// start is taken in every cycle (busy stays low); o_done strobes each result once.
// The receiver cannot stall. Synchronous reset empties the pipe, radius to 6378137 m.
module great_circle_distance_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [31:0] i_lon_b,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [23:0]        i_cfg_earth_radius,
    output logic               o_done,
    output logic [32:0]        o_distance_cm
);
    import gcd_pkg::*;

    localparam int LATENCY = 2 * CORDIC_STAGES + 39;
    localparam int ST_C    = CORDIC_STAGES + 5;

    function automatic logic [30:0] to_rad(input logic [30:0] d);
        logic [63:0] p;
        p = 64'(d) * 64'(RAD_K) + 64'h8000_0000;
        return p[62:32];
    endfunction

    function automatic t_cw mulq(input t_cw a, input t_cw b);
        logic signed [2*CW-1:0] p;
        p = (2*CW)'(a) * (2*CW)'(b) + (2*CW)'(64'sd536870912);
        return t_cw'(p >>> 30);
    endfunction

    logic [LATENCY-1:0] r_valid;
    logic [23:0]        r_radius;

    // stage 1: wrap differences, fold latitudes
    logic signed [33:0] dlat, dlon, mlat, mlon, alat_a, alat_b;
    logic [31:0]        r_m_lat, r_m_lon;
    logic [29:0]        r_f_a, r_f_b;
    logic [1:0]         r_neg1;
    // stage 2 and 3
    logic [30:0]        r_d [4];
    logic [30:0]        r_rad [4];
    logic [1:0]         r_neg_line [CORDIC_STAGES+2];
    t_cordic_vec        w_rot_in [4];
    t_cordic_vec        w_rot_out [4];
    // products and haversine term
    t_cw                cos_a, cos_b;
    t_cw                r_s1sq, r_s2sq, r_cc, r_s1sq_b, r_t;
    logic signed [CW:0] h_sum;
    logic [30:0]        h_clamp;
    logic [30:0]        r_h, r_hc;
    logic [SQ_OUT_W-1:0] w_ys, w_xs;
    t_cordic_vec        w_vec_in, w_vec_out;
    // scaling
    logic [31:0]        ang;
    logic [55:0]        r_prod;
    logic [62:0]        scaled;
    logic [32:0]        r_dist;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_radius <= 24'd6378137;
        end else begin
            r_valid <= {r_valid[LATENCY-2:0], start};
            if (i_cfg_valid) r_radius <= i_cfg_earth_radius;
        end
    end

    always_comb begin
        dlat = 34'(i_lat_a) - 34'(i_lat_b);
        dlon = 34'(i_lon_a) - 34'(i_lon_b);
        mlat = (dlat < 0) ? dlat + FULL_TURN : dlat;
        if (dlon < -FULL_TURN)     mlon = dlon + TWO_TURNS;
        else if (dlon < 0)         mlon = dlon + FULL_TURN;
        else if (dlon >= FULL_TURN) mlon = dlon - FULL_TURN;
        else                       mlon = dlon;
        alat_a = (i_lat_a < 0) ? -34'(i_lat_a) : 34'(i_lat_a);
        alat_b = (i_lat_b < 0) ? -34'(i_lat_b) : 34'(i_lat_b);
    end

    always_ff @(posedge i_clk) begin
        r_m_lat   <= mlat[31:0];
        r_m_lon   <= mlon[31:0];
        r_neg1[0] <= alat_a > QUARTER_TURN;
        r_neg1[1] <= alat_b > QUARTER_TURN;
        r_f_a     <= (alat_a > QUARTER_TURN) ? 30'(HALF_TURN - alat_a) : alat_a[29:0];
        r_f_b     <= (alat_b > QUARTER_TURN) ? 30'(HALF_TURN - alat_b) : alat_b[29:0];

        // fold the half-angle sine into the first quadrant
        r_d[0] <= (34'(r_m_lat) > HALF_TURN) ? 31'(FULL_TURN - 34'(r_m_lat)) : r_m_lat[30:0];
        r_d[1] <= (34'(r_m_lon) > HALF_TURN) ? 31'(FULL_TURN - 34'(r_m_lon)) : r_m_lon[30:0];
        r_d[2] <= {r_f_a, 1'b0};
        r_d[3] <= {r_f_b, 1'b0};
        r_neg_line[0] <= r_neg1;
        for (int k = 1; k < CORDIC_STAGES + 2; k++) r_neg_line[k] <= r_neg_line[k-1];

        for (int k = 0; k < 4; k++) r_rad[k] <= to_rad(r_d[k]);
    end

    for (genvar g = 0; g < 4; g++) begin : g_rot
        assign w_rot_in[g].x = INV_GAIN;
        assign w_rot_in[g].y = '0;
        assign w_rot_in[g].z = t_cw'(r_rad[g]);
        gcd_cordic_chain u_rot (
            .i_clk       (i_clk),
            .i_vectoring (1'b0),
            .i_vec       (w_rot_in[g]),
            .o_vec       (w_rot_out[g])
        );
    end

    always_comb begin
        cos_a   = r_neg_line[CORDIC_STAGES+1][0] ? -w_rot_out[2].x : w_rot_out[2].x;
        cos_b   = r_neg_line[CORDIC_STAGES+1][1] ? -w_rot_out[3].x : w_rot_out[3].x;
        h_sum   = (CW+1)'(r_s1sq_b) + (CW+1)'(r_t);
        if (h_sum < 0)                      h_clamp = '0;
        else if (h_sum > (CW+1)'(Q30_ONE))  h_clamp = Q30_ONE;
        else                                h_clamp = h_sum[30:0];
    end

    always_ff @(posedge i_clk) begin
        r_s1sq   <= mulq(w_rot_out[0].y, w_rot_out[0].y);
        r_s2sq   <= mulq(w_rot_out[1].y, w_rot_out[1].y);
        r_cc     <= mulq(cos_a, cos_b);
        r_s1sq_b <= r_s1sq;
        r_t      <= mulq(r_cc, r_s2sq);
        r_h      <= h_clamp;
        r_hc     <= Q30_ONE - h_clamp;
    end

    gcd_sqrt_chain u_sqrt_y (
        .i_clk  (i_clk),
        .i_n    ({r_h, 30'b0}),
        .o_root (w_ys)
    );

    gcd_sqrt_chain u_sqrt_x (
        .i_clk  (i_clk),
        .i_n    ({r_hc, 30'b0}),
        .o_root (w_xs)
    );

    assign w_vec_in.x = t_cw'(w_xs);
    assign w_vec_in.y = t_cw'(w_ys);
    assign w_vec_in.z = '0;

    gcd_cordic_chain u_asin (
        .i_clk       (i_clk),
        .i_vectoring (1'b1),
        .i_vec       (w_vec_in),
        .o_vec       (w_vec_out)
    );

    always_comb begin
        // drop a negative angle to zero, then double it
        ang    = w_vec_out.z[CW-1] ? '0 : {w_vec_out.z[30:0], 1'b0};
        scaled = {1'b0, r_prod, 6'b0} + {2'b0, r_prod, 5'b0} + {5'b0, r_prod, 2'b0}
                 + 63'h2000_0000;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 56'(ang) * 56'(r_radius);
        r_dist <= scaled[62:30];
    end

    assign o_done        = r_valid[LATENCY-1];
    assign o_distance_cm = r_dist;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_done)
        else $error("item did not leave after the pipeline latency");

    a_h_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[ST_C] |-> (32'(r_h) + 32'(r_hc)) == 32'(Q30_ONE))
        else $error("haversine term and its complement do not sum to one");

    a_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] |-> (34'(r_d[0]) <= HALF_TURN) && (34'(r_d[1]) <= HALF_TURN)
                      && (34'(r_d[2]) <= HALF_TURN) && (34'(r_d[3]) <= HALF_TURN))
        else $error("folded angle outside the first half turn");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_valid[ST_C], LATENCY - 1 - ST_C))
        else $error("result strobe without an item in flight");

endmodule

// File: bench/gcd_checker.sv
`timescale 1ns / 1ps
// Result checker for the great-circle distance unit: predicts each distance from the
// accepted item and the current radius, and compares in order. Depends on gcd_pkg.
module gcd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [31:0] i_lon_b,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [23:0]        i_cfg_earth_radius,
    input  logic               o_done,
    input  logic [32:0]        o_distance_cm,
    output int                 o_errors,
    output int                 o_pending
);
    import gcd_pkg::*;

    localparam longint DEG_FULL    = 64'sd3600000000;
    localparam longint DEG_HALF    = 64'sd1800000000;
    localparam longint DEG_QUARTER = 64'sd900000000;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint HALF_Q30    = 64'sd536870912;
    localparam longint GAIN_INV    = 64'sd652032874;
    localparam longint unsigned K_RAD = 64'd4024455254;
    localparam logic [23:0] RADIUS_AT_RESET = 24'd6378137;

    logic [32:0] distance_q[$];
    logic [23:0] radius;
    int          mismatches;

    function automatic longint arctan_step(input int i);
        longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return tbl[i];
        if (i <= 30) return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + HALF_Q30) >>> 30;
    endfunction

    function automatic longint half_deg_to_rad(input longint d);
        longint unsigned p;
        p = longint'(d) * K_RAD + 64'd2147483648;
        return longint'(p >> 32);
    endfunction

    function automatic longint rotate_sin_cos(input longint z, input bit want_sin);
        longint x, y, dx, dy;
        x = GAIN_INV;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - arctan_step(i);
            end else begin
                x = x + dx; y = y - dy; z = z + arctan_step(i);
            end
        end
        return want_sin ? y : x;
    endfunction

    function automatic longint vector_angle(input longint x, input longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + arctan_step(i);
            end else begin
                x = x - dx; y = y + dy; z = z - arctan_step(i);
            end
        end
        return z;
    endfunction

    // fold the difference to [0, 180] so the half angle lies in [0, 90]
    function automatic longint sin_half_diff(input longint d);
        longint m;
        m = ((d % DEG_FULL) + DEG_FULL) % DEG_FULL;
        if (m > DEG_HALF) m = DEG_FULL - m;
        return rotate_sin_cos(half_deg_to_rad(m), 1'b1);
    endfunction

    function automatic longint cos_of_lat(input longint lat);
        longint a;
        bit     flip;
        a = lat < 0 ? -lat : lat;
        flip = 1'b0;
        if (a > DEG_QUARTER) begin
            a = DEG_HALF - a;
            flip = 1'b1;
        end
        a = rotate_sin_cos(half_deg_to_rad(2 * a), 1'b0);
        return flip ? -a : a;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [32:0] predict_distance(input longint la, input longint loa,
                                                     input longint lb, input longint lob,
                                                     input logic [23:0] rad_m);
        longint s1, s2, cc, h, z;
        longint unsigned ys, xs, prod;
        s1 = sin_half_diff(la - lb);
        s2 = sin_half_diff(loa - lob);
        cc = qmul(cos_of_lat(la), cos_of_lat(lb));
        h  = qmul(s1, s1) + qmul(cc, qmul(s2, s2));
        if (h < 0) h = 0;
        if (h > ONE_Q30) h = ONE_Q30;
        ys = floor_sqrt(longint'(h) << 30);
        xs = floor_sqrt(longint'(ONE_Q30 - h) << 30);
        z  = vector_angle(longint'(xs), longint'(ys));
        if (z < 0) z = 0;
        prod = (longint'(z) * 2) * longint'(rad_m) * 100 + 64'd536870912;
        return 33'(prod >> 30);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            distance_q.delete();
            radius     <= RADIUS_AT_RESET;
            mismatches = 0;
            o_pending  <= 0;
            o_errors   <= 0;
        end else begin
            if (o_done) begin
                if (distance_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: distance_cm=%0d", o_distance_cm);
                end else begin
                    if (o_distance_cm !== distance_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("distance mismatch: expected %0d, got %0d",
                                     distance_q[0], o_distance_cm);
                    end
                    void'(distance_q.pop_front());
                end
            end
            // append the prediction at the tail of the queue
            if (start && !busy)
                distance_q.insert(distance_q.size(),
                                  predict_distance(i_lat_a, i_lon_a, i_lat_b, i_lon_b,
                                                   radius));
            if (i_cfg_valid && o_cfg_ready) radius <= i_cfg_earth_radius;
            o_pending <= distance_q.size();
            o_errors  <= mismatches;
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the great-circle distance unit; checking is done by
// gcd_checker. Depends on gcd_pkg, great_circle_distance_unit and gcd_checker.
module tb_top;
    import gcd_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [30:0] i_lat_a;
    logic signed [31:0] i_lon_a;
    logic signed [30:0] i_lat_b;
    logic signed [31:0] i_lon_b;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [23:0]        i_cfg_earth_radius;
    logic               o_done;
    logic [32:0]        o_distance_cm;
    int                 errors;
    int                 pending;
    bit                 allow_idle;

    great_circle_distance_unit DUT (.*);

    gcd_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_lat_a, .i_lon_a, .i_lat_b, .i_lon_b,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_earth_radius, .o_done, .o_distance_cm,
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    task automatic send_item(input int la, input int loa, input int lb, input int lob);
        int gap;
        @(negedge i_clk);
        if (allow_idle && $urandom_range(0, 7) == 0) begin
            start = 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge i_clk);
        end
        start   = 1'b1;
        i_lat_a = la[30:0];
        i_lon_a = loa;
        i_lat_b = lb[30:0];
        i_lon_b = lob;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // hold off until the pipe is empty, then load the radius
    task automatic write_radius(input logic [23:0] value);
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        i_cfg_valid        = 1'b1;
        i_cfg_earth_radius = value;
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic int rand_lat();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1800000000) - 900000000;
        return int'($signed(31'($urandom())));
    endfunction

    function automatic int rand_lon();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2000000000) - 1000000000
                                            + ($urandom_range(0, 1) ? 800000000 : -800000000);
        return int'($urandom());
    endfunction

    task automatic random_phase(input int count);
        int la;
        int lo;
        for (int n = 0; n < count; n++) begin
            la = rand_lat();
            lo = rand_lon();
            // one in three nearby pairs, the rest independent points
            if ($urandom_range(0, 2) == 0)
                send_item(la, lo, la + $urandom_range(0, 2000000) - 1000000,
                          lo + $urandom_range(0, 2000000) - 1000000);
            else
                send_item(la, lo, rand_lat(), rand_lon());
        end
    endtask

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_lat_a = '0; i_lon_a = '0; i_lat_b = '0; i_lon_b = '0;
        i_cfg_valid = 1'b0;
        i_cfg_earth_radius = '0;
        allow_idle = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, wraps, poles, antipodes, latitudes past the pole
        send_item(0, 0, 0, 0);
        send_item(900000000, 0, -900000000, 0);
        send_item(0, 0, 0, 1800000000);
        send_item(0, -1800000000, 0, 1800000000);
        send_item(0, 1799999999, 0, -1799999999);
        send_item(-900000000, -1800000000, 900000000, 1800000000);
        send_item(450000000, 100000000, -450000000, -1700000000);
        send_item(-1073741824, 0, 1073741823, 0);
        send_item(1073741823, 2147483647, -1073741824, -2147483648);
        send_item(0, 2147483647, 0, -2147483648);
        send_item(950000000, 0, 950000000, 1800000000);
        send_item(1000000000, 300000000, -1000000000, 20000000);
        send_item(123456789, 987654321, 123456789, 987654322);
        send_item(0, 0, 1, 1);
        send_item(-1, -1, 0, 0);
        send_item(899999999, 0, 900000000, 1800000000);
        send_item(0, 900000000, 0, -900000000);

        random_phase(300);
        write_radius(24'd1);
        send_item(0, 0, 0, 1800000000);
        random_phase(300);
        write_radius(24'hFFFFFF);
        send_item(0, 0, 0, 1800000000);
        send_item(900000000, 0, -900000000, 0);
        random_phase(300);
        write_radius(24'd0);
        random_phase(60);
        write_radius(24'($urandom_range(1, 16777215)));
        random_phase(300);
        write_radius(24'd6378137);
        allow_idle = 1'b0;
        random_phase(300);

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
